// ----- src/pal_pkg.sv -----
package pal_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } pal_cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } pal_status_t;

  localparam int PosW    = 8;
  localparam int KeyW    = 32;
  localparam int IndexW  = 7;
  localparam int CountW  = 8;
  localparam int StatusW = 3;
  localparam int CmdW    = 2;

endpackage

// ----- src/positional_array_list_core.sv -----
// Positional array list: an ordered list of up to DEPTH 32-bit keys, packed from index 0.
// Input channel (in_valid/in_stall) carries one command per transaction: insert a key
// at a position (a position at or beyond the count appends), remove the entry at a
// position, or find the lowest index holding a key. Result channel (out_valid/out_stall)
// returns exactly one transaction per command: status, removed key, index and new count.
// The keys sit in a single-port-write, registered-read memory; every shift or compare
// streams through it one entry per cycle, read and write-back overlapping.
// Insert shifts the entries from the end down to the position up by one, then writes the
// key (an append only writes the key); remove keeps the key at the position and shifts the
// entries above it down; find compares upward to the first match or the end. Failures and
// the unused code go straight to the result register load; the next command can be
// accepted in the cycle after that load, even while that result is still held by out_stall.
// One command is in work at a time; in_stall is high from accept until the result
// moves to the output register. A result waiting under out_stall does not stop the
// next command from being accepted; that command then holds until the register frees.
// Reset (rst_n low, synchronous) holds in_stall high, empties the list and drops any
// pending result; the memory is not cleared, as entries at or beyond the count are
// never read.
module positional_array_list_core #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pal_pkg::CmdW-1:0]   in_command,
  input  logic [pal_pkg::PosW-1:0]   in_position,
  input  logic [pal_pkg::KeyW-1:0]   in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pal_pkg::StatusW-1:0] out_status,
  output logic [pal_pkg::KeyW-1:0]   out_key_out,
  output logic [pal_pkg::IndexW-1:0] out_index_out,
  output logic [pal_pkg::CountW-1:0] out_count_out
);

  import pal_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > PosW) ? CW : PosW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_KEY,
    S_DONE
  } state_t;

  logic [KeyW-1:0] mem [DEPTH];

  state_t             state_r, state_nxt;
  logic [CmdW-1:0]    cmd_r, cmd_nxt;
  logic [KeyW-1:0]    key_r, key_nxt;
  logic [AW-1:0]      at_r, at_nxt;
  logic [AW-1:0]      lim_r, lim_nxt;
  logic [AW-1:0]      ra_r, ra_nxt;
  logic               rd_more_r, rd_more_nxt;
  logic               p_valid_r, p_valid_nxt;
  logic [AW-1:0]      p_addr_r, p_addr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [StatusW-1:0] res_status_r, res_status_nxt;
  logic [KeyW-1:0]    res_key_r, res_key_nxt;
  logic [IndexW-1:0]  res_idx_r, res_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [StatusW-1:0] out_status_r, out_status_nxt;
  logic [KeyW-1:0]    out_key_r, out_key_nxt;
  logic [IndexW-1:0]  out_idx_r, out_idx_nxt;
  logic [CountW-1:0]  out_count_r, out_count_nxt;

  logic [KeyW-1:0]    rd_data_r;
  logic               rd_en;
  logic               we;
  logic [AW-1:0]      wa;
  logic [KeyW-1:0]    wd;

  logic               accept;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      cnt_ext;
  logic [AW-1:0]      at_pos;

  assign in_stall      = !rst_n || (state_r != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_key_r;
  assign out_index_out = out_idx_r;
  assign out_count_out = out_count_r;

  assign pos_ext = PW'(in_position);
  assign cnt_ext = PW'(count_r);
  // clamp the insert point to the end of the list
  assign at_pos  = (pos_ext >= cnt_ext) ? AW'(count_r) : AW'(in_position);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    at_nxt         = at_r;
    lim_nxt        = lim_r;
    ra_nxt         = ra_r;
    rd_more_nxt    = rd_more_r;
    p_valid_nxt    = p_valid_r;
    p_addr_nxt     = p_addr_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_idx_nxt    = out_idx_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    we             = 1'b0;
    wa             = at_r;
    wd             = key_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key;
          res_status_nxt = ST_OK;
          res_key_nxt    = '0;
          res_idx_nxt    = '0;
          state_nxt      = S_DONE;
          case (in_command)
            CMD_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                at_nxt      = at_pos;
                count_nxt   = count_r + 1'b1;
                res_idx_nxt = IndexW'(at_pos);
                if (PW'(at_pos) == cnt_ext) begin
                  state_nxt = S_KEY;
                end else begin
                  ra_nxt      = AW'(count_r - 1'b1);
                  rd_more_nxt = 1'b1;
                  state_nxt   = S_RUN;
                end
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_status_nxt = ST_BADPOS;
              end else begin
                at_nxt      = AW'(in_position);
                ra_nxt      = AW'(in_position);
                lim_nxt     = AW'(count_r - 1'b1);
                count_nxt   = count_r - 1'b1;
                res_idx_nxt = IndexW'(in_position);
                rd_more_nxt = 1'b1;
                state_nxt   = S_RUN;
              end
            end
            CMD_FIND: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                ra_nxt      = '0;
                lim_nxt     = AW'(count_r - 1'b1);
                rd_more_nxt = 1'b1;
                state_nxt   = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        // issue side: one read a cycle, down for insert, up otherwise
        if (rd_more_r) begin
          rd_en       = 1'b1;
          p_valid_nxt = 1'b1;
          p_addr_nxt  = ra_r;
          if (cmd_r == CMD_INSERT) begin
            if (ra_r == at_r) rd_more_nxt = 1'b0;
            else              ra_nxt      = ra_r - 1'b1;
          end else begin
            if (ra_r == lim_r) rd_more_nxt = 1'b0;
            else               ra_nxt      = ra_r + 1'b1;
          end
        end else begin
          p_valid_nxt = 1'b0;
        end

        // return side: write back shifted or compare
        if (p_valid_r) begin
          case (cmd_r)
            CMD_INSERT: begin
              we = 1'b1;
              wa = p_addr_r + 1'b1;
              wd = rd_data_r;
            end
            CMD_REMOVE: begin
              if (p_addr_r == at_r) begin
                res_key_nxt = rd_data_r;
              end else begin
                we = 1'b1;
                wa = p_addr_r - 1'b1;
                wd = rd_data_r;
              end
            end
            CMD_FIND: begin
              if (rd_data_r == key_r) begin
                res_idx_nxt = IndexW'(p_addr_r);
                rd_more_nxt = 1'b0;
                p_valid_nxt = 1'b0;
                state_nxt   = S_DONE;
              end
            end
            default: begin
            end
          endcase
        end

        if (!rd_more_r && !p_valid_r) begin
          case (cmd_r)
            CMD_INSERT: state_nxt = S_KEY;
            CMD_FIND: begin
              res_status_nxt = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_KEY: begin
        we        = 1'b1;
        wa        = at_r;
        wd        = key_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_idx_nxt    = res_idx_r;
          out_count_nxt  = CountW'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_more_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_more_r   <= rd_more_nxt;
      p_valid_r   <= p_valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    at_r         <= at_nxt;
    lim_r        <= lim_nxt;
    ra_r         <= ra_nxt;
    p_addr_r     <= p_addr_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_idx_r    <= out_idx_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[ra_r];
    end
  end

endmodule

// ----- tb/sv/positional_array_list_core_tb.sv -----
`timescale 1ns / 1ps

module positional_array_list_core_tb;
  import pal_pkg::*;

  localparam int ListDepth  = 128;
  localparam int CycleLimit = 1_500_000;
  localparam int PrintLimit = 40;

  typedef struct packed {
    pal_status_t         status;
    logic [KeyW-1:0]     key;
    logic [IndexW-1:0]   index;
    logic [CountW-1:0]   count;
  } list_result_t;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIXED
  } traffic_phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CmdW-1:0]     in_command = CMD_NONE;
  logic [PosW-1:0]     in_position = '0;
  logic [KeyW-1:0]     in_key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [StatusW-1:0]  out_status;
  logic [KeyW-1:0]     out_key_out;
  logic [IndexW-1:0]   out_index_out;
  logic [CountW-1:0]   out_count_out;

  // Shadow of the list contents, updated as each command is accepted
  logic [KeyW-1:0]     shadow_keys [ListDepth];
  int                  shadow_count = 0;
  list_result_t        pending_results [$];

  int                  fail_count = 0;
  bit                  quiet_in = 1'b0;
  bit                  quiet_out = 1'b0;

  positional_array_list_core #(
    .DEPTH(ListDepth)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_key_out   (out_key_out),
    .out_index_out (out_index_out),
    .out_count_out (out_count_out)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (fail_count < PrintLimit) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_input_gap();
    if (quiet_in || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pick_idle_len();
  endfunction

  function automatic list_result_t apply_command(input pal_cmd_t cmd,
                                                 input logic [PosW-1:0] pos,
                                                 input logic [KeyW-1:0] key);
    list_result_t res;
    int           at;
    int           i;
    bit           hit;
    res.status = ST_OK;
    res.key    = '0;
    res.index  = '0;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_count >= ListDepth) begin
          res.status = ST_FULL;
        end else begin
          at = (int'(pos) >= shadow_count) ? shadow_count : int'(pos);
          for (i = shadow_count; i > at; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
          end
          shadow_keys[at] = key;
          shadow_count++;
          res.index = IndexW'(at);
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (int'(pos) >= shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.key = shadow_keys[pos];
          for (i = int'(pos); i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
          end
          shadow_count--;
          res.index = IndexW'(pos);
        end
      end
      CMD_FIND: begin
        hit = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_keys[i] == key) begin
            hit = 1'b1;
            res.index = IndexW'(i);
          end
        end
        if (!hit) begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    res.count = CountW'(shadow_count);
    return res;
  endfunction

  // Leaves in_valid high after the accepting edge so a back-to-back
  // transaction needs only one assignment to it
  task automatic send_command(input pal_cmd_t cmd, input logic [PosW-1:0] pos,
                              input logic [KeyW-1:0] key);
    int gap;
    gap = pick_input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_key      <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_command(cmd, pos, key));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return KeyW'($urandom_range(0, 15));
    end else if (r < 34) begin
      return '0;
    end else if (r < 38) begin
      return '1;
    end else if (r < 41) begin
      return 32'h8000_0000;
    end else if (r < 44) begin
      return 32'h7FFF_FFFF;
    end
    return $urandom();
  endfunction

  function automatic logic [KeyW-1:0] pick_find_key();
    if (shadow_count > 0 && $urandom_range(0, 99) < 60) begin
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    end
    return pick_key();
  endfunction

  function automatic logic [PosW-1:0] pick_position(input pal_cmd_t cmd);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return '1;
    end else if (r < 12) begin
      return PosW'($urandom_range(128, 255));
    end else if (r < 18) begin
      return PosW'(shadow_count);
    end else if (r < 23) begin
      return '0;
    end else if (r < 28 && shadow_count > 0) begin
      return PosW'(shadow_count - 1);
    end else if (cmd == CMD_REMOVE && shadow_count > 0) begin
      return PosW'($urandom_range(0, shadow_count - 1));
    end
    return PosW'($urandom_range(0, shadow_count));
  endfunction

  function automatic pal_cmd_t pick_command(input int ins_pct, input int rem_pct,
                                            input int find_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      return CMD_INSERT;
    end else if (r < ins_pct + rem_pct) begin
      return CMD_REMOVE;
    end else if (r < ins_pct + rem_pct + find_pct) begin
      return CMD_FIND;
    end
    return CMD_NONE;
  endfunction

  task automatic test_empty_list();
    send_command(CMD_REMOVE, 8'd0, 32'h0);
    send_command(CMD_REMOVE, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'd0, 32'h0);
    send_command(CMD_NONE, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'd0, 32'h0);
    send_command(CMD_REMOVE, 8'd1, 32'h0);
    send_command(CMD_REMOVE, 8'd0, 32'h0);
    wait_idle();
  endtask

  task automatic test_positional_shifts();
    send_command(CMD_INSERT, 8'd0, 32'h0000_0001);
    send_command(CMD_INSERT, 8'd0, 32'h0000_0002);
    send_command(CMD_INSERT, 8'd1, 32'h0000_0003);
    send_command(CMD_INSERT, 8'd3, 32'h8000_0000);
    send_command(CMD_INSERT, 8'd200, 32'h0);
    send_command(CMD_INSERT, 8'd128, 32'h0000_0002);
    send_command(CMD_FIND, 8'd0, 32'h0000_0002);
    send_command(CMD_FIND, 8'hAA, 32'h0);
    send_command(CMD_FIND, 8'd0, 32'h7FFF_FFFF);
    send_command(CMD_NONE, 8'h55, 32'hA5A5_5A5A);
    send_command(CMD_REMOVE, 8'd2, 32'h0);
    send_command(CMD_REMOVE, PosW'(shadow_count - 1), 32'h0);
    send_command(CMD_REMOVE, 8'd0, 32'hFFFF_FFFF);
    send_command(CMD_REMOVE, 8'd200, 32'h0);
    wait_idle();
  endtask

  task automatic test_full_list();
    int i;
    i = 0;
    while (shadow_count < ListDepth) begin
      send_command(CMD_INSERT, PosW'($urandom_range(shadow_count, 255)),
                   32'h5A00_0000 + i);
      i++;
    end
    send_command(CMD_INSERT, 8'd0, 32'h1234_5678);
    send_command(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'd0, shadow_keys[ListDepth-1]);
    send_command(CMD_REMOVE, 8'd128, 32'h0);
    send_command(CMD_REMOVE, 8'd127, 32'h0);
    send_command(CMD_REMOVE, 8'd0, 32'h0);
    send_command(CMD_INSERT, 8'd0, 32'h0);
    send_command(CMD_INSERT, 8'd126, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'd0, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_items);
    traffic_phase_t phase;
    int             phase_left;
    int             sent;
    pal_cmd_t       cmd;
    logic [KeyW-1:0] key;
    phase = PHASE_MIXED;
    phase_left = 0;
    sent = 0;
    while (sent < n_items) begin
      if (phase_left == 0) begin
        phase = traffic_phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(40, 200);
        quiet_in = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
      end
      case (phase)
        PHASE_FILL:  cmd = pick_command(75, 10, 12);
        PHASE_DRAIN: cmd = pick_command(10, 75, 12);
        default:     cmd = pick_command(40, 35, 22);
      endcase
      key = (cmd == CMD_FIND) ? pick_find_key() : pick_key();
      send_command(cmd, pick_position(cmd), key);
      // cut a fill short once the list has been seen full
      if (phase == PHASE_FILL && shadow_count == ListDepth && $urandom_range(0, 9) == 0) begin
        phase_left = 1;
      end
      phase_left--;
      sent++;
    end
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    wait_idle();
  endtask

  // Random back-pressure on the result channel
  always @(posedge clk) begin : out_stall_gen
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet_out && $urandom_range(0, 99) < 25) begin
      stall_left = pick_idle_len();
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no command outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
        end
        if (out_key_out !== want.key) begin
          report_mismatch($sformatf("key_out got %h want %h", out_key_out, want.key));
        end
        if (out_index_out !== want.index) begin
          report_mismatch($sformatf("index_out got %0d want %0d", out_index_out,
                                    want.index));
        end
        if (out_count_out !== want.count) begin
          report_mismatch($sformatf("count_out got %0d want %0d", out_count_out,
                                    want.count));
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("positional_array_list_core_tb failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_positional_shifts();
    test_full_list();
    test_random_traffic(1250);
    wait_idle();
    // let any stray transaction surface
    repeat (ListDepth + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("positional_array_list_core_tb passed");
    end else begin
      $display("positional_array_list_core_tb failed");
    end
    $finish;
  end

endmodule
